// File: src/olpfe_pkg.sv
package olpfe_pkg;

    // operation codes of a request
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_LIST   = 2'd2,
        OP_PASS   = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // where a result value comes from
    typedef enum logic [1:0] {
        SRC_REQ  = 2'd0,
        SRC_RD   = 2'd1,
        SRC_ZERO = 2'd2
    } t_src;

    // request payload
    typedef struct packed {
        logic [1:0]          operation;
        logic signed [31:0]  item_value;
    } t_req;

    // result payload
    typedef struct packed {
        logic signed [31:0]  out_value;
        logic [1:0]          status;
        logic [5:0]          entry_count;
        logic                last;
    } t_rsp;

    // controller to datapath commands
    typedef struct packed {
        logic     load;
        logic     insert;
        logic     start_read;
        logic     issue;
        logic     shift_start;
        logic     shift_write;
        logic     erase_done;
        logic     emit;
        t_status  emit_status;
        t_src     emit_src;
        logic     emit_last;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        t_op   op;
        logic  full;
        logic  empty;
        logic  rd_vld;
        logic  match;
        logic  rd_last;
        logic  rem_zero;
        logic  shift_last;
    } t_dp_sts;

endpackage

// File: src/ordered_list_push_front_erase.sv
// Ordered list of up to CAPACITY signed 32-bit values, newest at the front, kept in a
// ring buffer memory with one write and one registered read port. A request is taken
// when start is high and busy is low; results appear on o_rsp for one cycle each,
// marked by o_strobe, and cannot be held off. Insert and the unused fourth operation
// finish in the execute state and give their result on the following cycle. List
// streams one entry per cycle, the final one marked last; an empty list gives a
// single empty result. Erase walks the memory one entry per cycle to the first
// match at position i, then moves the count - 1 - i entries behind it forward one
// per cycle; the single memory read port sets this pace. The unit takes one request
// at a time.
module ordered_list_push_front_erase #(
    parameter int CAPACITY = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  olpfe_pkg::t_req   i_req,
    output logic              o_strobe,
    output olpfe_pkg::t_rsp   o_rsp
);
    import olpfe_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing
    olpfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // storage and result path
    olpfe_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but unit not busy");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_strobe && o_rsp.last))
        else $error("request finished without a final result");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.last) |-> !busy)
        else $error("final result while still busy");
`endif

endmodule

// File: src/olpfe_ctrl.sv
module olpfe_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    output olpfe_pkg::t_dp_cmd o_cmd,
    input  olpfe_pkg::t_dp_sts i_sts
);
    import olpfe_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_LIST  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_SHIFT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.op)
                    OP_INSERT: begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_src  = SRC_REQ;
                        o_cmd.emit_last = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.emit_status = ST_FULL;
                        end else begin
                            o_cmd.insert      = 1'b1;
                            o_cmd.emit_status = ST_OK;
                        end
                        n_state = S_IDLE;
                    end
                    OP_ERASE: begin
                        if (i_sts.empty) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_src    = SRC_REQ;
                            o_cmd.emit_status = ST_NOT_FOUND;
                            o_cmd.emit_last   = 1'b1;
                            n_state           = S_IDLE;
                        end else begin
                            o_cmd.start_read = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    OP_LIST: begin
                        if (i_sts.empty) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_src    = SRC_ZERO;
                            o_cmd.emit_status = ST_EMPTY;
                            o_cmd.emit_last   = 1'b1;
                            n_state           = S_IDLE;
                        end else begin
                            o_cmd.start_read = 1'b1;
                            n_state          = S_LIST;
                        end
                    end
                    OP_PASS: begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_src    = SRC_REQ;
                        o_cmd.emit_status = ST_OK;
                        o_cmd.emit_last   = 1'b1;
                        n_state           = S_IDLE;
                    end
                endcase
            end
            S_LIST: begin
                // stream entries front to back
                o_cmd.issue = 1'b1;
                if (i_sts.rd_vld) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_src    = SRC_RD;
                    o_cmd.emit_status = ST_OK;
                    o_cmd.emit_last   = i_sts.rd_last;
                    if (i_sts.rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                // search for the first matching entry
                if (i_sts.rd_vld && i_sts.match) begin
                    if (i_sts.rem_zero) begin
                        o_cmd.erase_done  = 1'b1;
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_src    = SRC_REQ;
                        o_cmd.emit_status = ST_OK;
                        o_cmd.emit_last   = 1'b1;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.shift_start = 1'b1;
                        n_state           = S_SHIFT;
                    end
                end else if (i_sts.rd_vld && i_sts.rd_last) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_src    = SRC_REQ;
                    o_cmd.emit_status = ST_NOT_FOUND;
                    o_cmd.emit_last   = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            S_SHIFT: begin
                // close the gap, one entry per cycle
                o_cmd.issue = 1'b1;
                if (i_sts.rd_vld) begin
                    o_cmd.shift_write = 1'b1;
                    if (i_sts.shift_last) begin
                        o_cmd.erase_done  = 1'b1;
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_src    = SRC_REQ;
                        o_cmd.emit_status = ST_OK;
                        o_cmd.emit_last   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: src/olpfe_dp.sv
module olpfe_dp #(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  olpfe_pkg::t_req    i_req,
    input  olpfe_pkg::t_dp_cmd i_cmd,
    output olpfe_pkg::t_dp_sts o_sts,
    output logic               o_strobe,
    output olpfe_pkg::t_rsp    o_rsp
);
    import olpfe_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // ring buffer pointer stepping
    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        if (p == PW'(CAPACITY - 1)) begin
            q = '0;
        end else begin
            q = p + PW'(1);
        end
        return q;
    endfunction

    function automatic logic [PW-1:0] ptr_prev(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        if (p == '0) begin
            q = PW'(CAPACITY - 1);
        end else begin
            q = p - PW'(1);
        end
        return q;
    endfunction

    logic signed [31:0] mem [CAPACITY];

    t_op                r_op;
    logic signed [31:0] r_val;
    logic [PW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [PW-1:0]      r_iss_ptr;
    logic [CW-1:0]      r_iss_idx;
    logic [CW-1:0]      r_iss_left;
    logic               r_rd_vld;
    logic [CW-1:0]      r_rd_idx;
    logic [PW-1:0]      r_rd_ptr;
    logic signed [31:0] r_rd_data;
    logic [PW-1:0]      r_wr_ptr;
    logic [CW-1:0]      r_rem;
    t_rsp               r_out;
    t_rsp               n_out;
    logic               r_out_vld;

    logic [PW-1:0]      head_prev;
    logic               issue_ok;
    logic [CW-1:0]      count_m1;
    logic [CW-1:0]      match_rem;
    logic               wr_en;
    logic [PW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    // derived control values
    assign head_prev = ptr_prev(r_head);
    assign issue_ok  = i_cmd.issue && (r_iss_left != '0);
    assign count_m1  = r_count - CW'(1);
    assign match_rem = count_m1 - r_rd_idx;

    always_comb begin
        priority if (i_cmd.insert) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.erase_done) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    // status towards the controller
    always_comb begin
        o_sts.op         = r_op;
        o_sts.full       = (r_count == CW'(CAPACITY));
        o_sts.empty      = (r_count == '0);
        o_sts.rd_vld     = r_rd_vld;
        o_sts.match      = (r_rd_data == r_val);
        o_sts.rd_last    = (r_rd_idx == count_m1);
        o_sts.rem_zero   = (match_rem == '0);
        o_sts.shift_last = (r_rem == CW'(1));
    end

    // memory write port: front insert or gap closing
    assign wr_en   = i_cmd.insert || i_cmd.shift_write;
    assign wr_addr = i_cmd.insert ? head_prev : r_wr_ptr;
    assign wr_data = i_cmd.insert ? r_val : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[r_iss_ptr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_head     <= '0;
            r_rd_vld   <= 1'b0;
            r_iss_left <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_rd_vld  <= issue_ok;
            r_out_vld <= i_cmd.emit;
            if (i_cmd.insert) begin
                r_head <= head_prev;
            end
            priority if (i_cmd.start_read) begin
                r_iss_ptr  <= r_head;
                r_iss_idx  <= '0;
                r_iss_left <= r_count;
            end else if (i_cmd.shift_start) begin
                r_iss_ptr  <= ptr_next(r_rd_ptr);
                r_iss_left <= match_rem;
                r_wr_ptr   <= r_rd_ptr;
                r_rem      <= match_rem;
            end else if (issue_ok) begin
                r_iss_ptr  <= ptr_next(r_iss_ptr);
                r_iss_idx  <= r_iss_idx + CW'(1);
                r_iss_left <= r_iss_left - CW'(1);
            end
            if (i_cmd.shift_write) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
                r_rem    <= r_rem - CW'(1);
            end
        end
    end

    // result value selection
    always_comb begin
        n_out.status      = i_cmd.emit_status;
        n_out.entry_count = 6'(n_count);
        n_out.last        = i_cmd.emit_last;
        unique case (i_cmd.emit_src)
            SRC_REQ:  n_out.out_value = r_val;
            SRC_RD:   n_out.out_value = r_rd_data;
            SRC_ZERO: n_out.out_value = '0;
            default:  n_out.out_value = r_val;
        endcase
    end

    // request capture, read tags and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_req.operation);
            r_val <= i_req.item_value;
        end
        r_rd_idx <= r_iss_idx;
        r_rd_ptr <= r_iss_ptr;
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_strobe = r_out_vld;
    assign o_rsp    = r_out;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_insert_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> (r_count != CW'(CAPACITY)))
        else $error("insert into a full list");

    a_shift_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_write |-> r_rd_vld)
        else $error("gap closing write without read data");
`endif

endmodule

// File: verif/olpfe_result_checker.sv
module olpfe_result_checker #(
    parameter int CAPACITY = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  olpfe_pkg::t_req   i_req,
    input  logic              i_strobe,
    input  olpfe_pkg::t_rsp   i_rsp,
    output int                o_fail_count,
    output int                o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import olpfe_pkg::*;

    // shadow copy of the list, front at index 0
    logic signed [31:0] shadow_list [CAPACITY];
    int                 shadow_len = 0;

    // results still owed by the block, oldest first
    t_rsp               owed_results [$];
    int                 fail_count = 0;
    int                 outstanding = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding;

    function automatic t_rsp make_result(logic signed [31:0] value, t_status status,
                                         logic last);
        t_rsp r;
        r.out_value   = value;
        r.status      = status;
        r.entry_count = 6'(shadow_len);
        r.last        = last;
        return r;
    endfunction

    // work out the results of one request and update the shadow list
    task automatic apply_list_request(t_req req);
        int   hit;
        t_op  op;
        op  = t_op'(req.operation);
        hit = -1;
        case (op)
            OP_INSERT: begin
                if (shadow_len >= CAPACITY) begin
                    owed_results.push_back(make_result(req.item_value, ST_FULL, 1'b1));
                end else begin
                    for (int i = shadow_len; i > 0; i--) shadow_list[i] = shadow_list[i - 1];
                    shadow_list[0] = req.item_value;
                    shadow_len++;
                    owed_results.push_back(make_result(req.item_value, ST_OK, 1'b1));
                end
            end
            OP_ERASE: begin
                for (int i = 0; i < shadow_len; i++) begin
                    if (hit < 0 && shadow_list[i] == req.item_value) hit = i;
                end
                if (hit < 0) begin
                    owed_results.push_back(make_result(req.item_value, ST_NOT_FOUND, 1'b1));
                end else begin
                    for (int j = hit; j + 1 < shadow_len; j++) shadow_list[j] = shadow_list[j + 1];
                    shadow_len--;
                    owed_results.push_back(make_result(req.item_value, ST_OK, 1'b1));
                end
            end
            OP_LIST: begin
                if (shadow_len == 0) begin
                    owed_results.push_back(make_result('0, ST_EMPTY, 1'b1));
                end else begin
                    for (int i = 0; i < shadow_len; i++) begin
                        owed_results.push_back(make_result(shadow_list[i], ST_OK,
                                                           i == shadow_len - 1));
                    end
                end
            end
            default: begin
                // unused code: echo the value, list untouched
                owed_results.push_back(make_result(req.item_value, ST_OK, 1'b1));
            end
        endcase
    endtask

    // one line per mismatch
    task automatic flag_mismatch(string what, longint want, longint got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what, want, got);
    endtask

    // compare results first, then predict any request taken at the same edge
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            shadow_len = 0;
            owed_results.delete();
        end else begin
            if (i_strobe) begin
                if (owed_results.size() == 0) begin
                    flag_mismatch("unexpected result, value", 0, i_rsp.out_value);
                end else begin
                    want = owed_results.pop_front();
                    if (i_rsp.out_value !== want.out_value)
                        flag_mismatch("out_value", want.out_value, i_rsp.out_value);
                    if (i_rsp.status !== want.status)
                        flag_mismatch("status", want.status, i_rsp.status);
                    if (i_rsp.entry_count !== want.entry_count)
                        flag_mismatch("entry_count", want.entry_count, i_rsp.entry_count);
                    if (i_rsp.last !== want.last)
                        flag_mismatch("last", want.last, i_rsp.last);
                end
            end
            if (i_start && !i_busy) apply_list_request(i_req);
        end
        outstanding = owed_results.size();
    end

endmodule

// File: verif/tb_ordered_list_push_front_erase.sv
module tb_ordered_list_push_front_erase;
    timeunit 1ns;
    timeprecision 1ps;

    import olpfe_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int RANDOM_ITEMS = 300;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

    // request mix of one random phase
    typedef enum {MIX_FILL, MIX_DRAIN, MIX_MIXED} t_mix;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    logic  busy;
    t_req  i_req   = '0;
    logic  o_strobe;
    t_rsp  o_rsp;
    int    fail_count;
    int    outstanding;
    int    idle_cycles = 0;

    ordered_list_push_front_erase #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    olpfe_result_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (i_req),
        .i_strobe      (o_strobe),
        .i_rsp         (o_rsp),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog on cycles with neither a request nor a result taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // mostly a small pool so erases find matches, some extremes, some anything
    function automatic logic signed [31:0] pick_value();
        int roll;
        int corner;
        roll   = $urandom_range(0, 99);
        corner = $urandom_range(0, 3);
        if (roll < 70) return 32'(int'($urandom_range(0, 7)) - 4);
        if (roll < 80) begin
            if (corner == 0) return 32'h7fff_ffff;
            if (corner == 1) return 32'h8000_0000;
            if (corner == 2) return 32'h0;
            return 32'hffff_ffff;
        end
        return $urandom;
    endfunction

    function automatic t_op pick_op(t_mix mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                if (roll < 80) return OP_INSERT;
                if (roll < 88) return OP_ERASE;
                if (roll < 96) return OP_LIST;
            end
            MIX_DRAIN: begin
                if (roll < 70) return OP_ERASE;
                if (roll < 80) return OP_INSERT;
                if (roll < 94) return OP_LIST;
            end
            default: begin
                if (roll < 40) return OP_INSERT;
                if (roll < 70) return OP_ERASE;
                if (roll < 90) return OP_LIST;
            end
        endcase
        return OP_PASS;
    endfunction

    // mostly back to back or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_request(t_op op, logic signed [31:0] value);
        t_req req;
        req.operation  = op;
        req.item_value = value;
        start <= 1'b1;
        i_req <= req;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_then_idle(t_op op, logic signed [31:0] value, bit gaps_on);
        int gap;
        send_request(op, value);
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    initial begin
        int   sent;
        int   span;
        int   phase;
        bit   gaps_on;
        t_mix mix;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list cases, extremes, duplicates, first-match erase
        send_then_idle(OP_LIST,   32'h0,         1'b1);
        send_then_idle(OP_ERASE,  32'd5,         1'b1);
        send_then_idle(OP_PASS,   32'h8000_0000, 1'b1);
        send_then_idle(OP_INSERT, 32'h7fff_ffff, 1'b0);
        send_then_idle(OP_INSERT, 32'h8000_0000, 1'b0);
        send_then_idle(OP_INSERT, 32'h0,         1'b1);
        send_then_idle(OP_INSERT, 32'hffff_ffff, 1'b0);
        send_then_idle(OP_INSERT, 32'd7,         1'b1);
        send_then_idle(OP_INSERT, 32'd7,         1'b0);
        send_then_idle(OP_LIST,   32'hffff_ffff, 1'b0);
        send_then_idle(OP_ERASE,  32'd7,         1'b1);
        send_then_idle(OP_ERASE,  32'h7fff_ffff, 1'b0);
        send_then_idle(OP_ERASE,  32'h0,         1'b1);
        send_then_idle(OP_ERASE,  32'd12345,     1'b0);
        send_then_idle(OP_LIST,   32'h0,         1'b1);
        send_then_idle(OP_PASS,   32'd5,         1'b0);
        send_then_idle(OP_ERASE,  32'd7,         1'b0);
        send_then_idle(OP_ERASE,  32'hffff_ffff, 1'b1);
        send_then_idle(OP_ERASE,  32'h8000_0000, 1'b0);
        send_then_idle(OP_LIST,   32'h0,         1'b0);
        send_then_idle(OP_INSERT, 32'h5555_5555, 1'b1);
        send_then_idle(OP_INSERT, 32'haaaa_aaaa, 1'b0);
        send_then_idle(OP_LIST,   32'h0,         1'b1);
        send_then_idle(OP_ERASE,  32'haaaa_aaaa, 1'b0);
        send_then_idle(OP_ERASE,  32'h5555_5555, 1'b1);

        // random phases; the first one sends 60 requests, mostly inserts, to fill the list
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            mix     = (phase == 0) ? MIX_FILL : t_mix'($urandom_range(0, 2));
            span    = (phase == 0) ? 60 : $urandom_range(20, 45);
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
                send_then_idle(pick_op(mix), pick_value(), gaps_on);
                sent++;
            end
            phase++;
        end

        start <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
src/olpfe_pkg.sv
src/olpfe_ctrl.sv
src/olpfe_dp.sv
src/ordered_list_push_front_erase.sv
verif/olpfe_result_checker.sv
verif/tb_ordered_list_push_front_erase.sv
